// ===== src/assert_macros.svh =====
// Assertion macros for the RTL of the line rasterizer, used by antialiased_line_rasterizer_core.
// Depends on nothing; each user supplies clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an implication holds at every clock edge outside reset.
`define ALR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition holds at every clock edge outside reset.
`define ALR_ASSERT_ALWAYS(label, cond, msg) \
    `ALR_ASSERT(label, 1'b1 |-> (cond), msg)

`endif

// ===== src/alr_pkg.sv =====
// Package for the antialiased line rasterizer: widths, constants and state type.
// Depends on nothing; used by alr_divider and antialiased_line_rasterizer_core.
`default_nettype none

package alr_pkg;

    localparam int COORD_BITS = 5;
    localparam int FRAC_BITS = 16;
    localparam int ALPHA_BITS = 8;
    localparam int MINOR_BITS = COORD_BITS + FRAC_BITS;
    localparam int PROD_BITS = FRAC_BITS + ALPHA_BITS;
    localparam int DIV_CNT_BITS = $clog2(MINOR_BITS);
    localparam int COLOR_BITS = 32;

    localparam logic [MINOR_BITS-1:0] FRAC_ONE = MINOR_BITS'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PIX0,
        ST_PIX1,
        ST_FLUSH
    } state_t;

endpackage

`default_nettype wire

// ===== src/antialiased_line_rasterizer_core.sv =====
// Channel   Handshake                  Fields
// request   start, taken when !busy    start_x, start_y, end_x, end_y, line_color
// pixel     strobe, one cycle, no hold pixel_x, pixel_y, pixel_color, last_pixel
//
// A request is set up in the idle state, then passes through the gradient divider
// unless both endpoints lie on the same major coordinate.
// Each major step visits the two pixel states, one per candidate pixel, and the line
// ends with a closing flush state; a request has at most 32 major steps.
// Each pixel waits in a holding register until the next one or the closing state,
// so the last one can be marked. Reset puts the sequencer in idle; the receiver
// cannot stall the pixel stream.
`default_nettype none
`include "assert_macros.svh"

module antialiased_line_rasterizer_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [alr_pkg::COORD_BITS-1:0]     start_x,
    input  wire logic [alr_pkg::COORD_BITS-1:0]     start_y,
    input  wire logic [alr_pkg::COORD_BITS-1:0]     end_x,
    input  wire logic [alr_pkg::COORD_BITS-1:0]     end_y,
    input  wire logic [alr_pkg::COLOR_BITS-1:0]     line_color,
    output logic                                    strobe,
    output logic [alr_pkg::COORD_BITS-1:0]          pixel_x,
    output logic [alr_pkg::COORD_BITS-1:0]          pixel_y,
    output logic [alr_pkg::COLOR_BITS-1:0]          pixel_color,
    output logic                                    last_pixel
);

    localparam int CB = alr_pkg::COORD_BITS;
    localparam int FB = alr_pkg::FRAC_BITS;
    localparam int MB = alr_pkg::MINOR_BITS;
    localparam int AB = alr_pkg::ALPHA_BITS;
    localparam int PB = alr_pkg::PROD_BITS;

    alr_pkg::state_t state_reg, state_next;

    logic                           steep_reg, steep_next;
    logic                           neg_reg, neg_next;
    logic [CB-1:0]                  maj_reg, maj_next;
    logic [CB-1:0]                  maj_end_reg, maj_end_next;
    logic [MB-1:0]                  minor_reg, minor_next;
    logic [MB-1:0]                  grad_reg, grad_next;
    logic [alr_pkg::COLOR_BITS-AB-1:0] color_reg, color_next;
    logic [AB-1:0]                  alpha_reg, alpha_next;
    logic [AB-1:0]                  a1_reg, a1_next;

    logic                           pend_valid_reg, pend_valid_next;
    logic [CB-1:0]                  pend_x_reg, pend_x_next;
    logic [CB-1:0]                  pend_y_reg, pend_y_next;
    logic [AB-1:0]                  pend_alpha_reg, pend_alpha_next;

    logic                           strobe_reg, strobe_next;
    logic [CB-1:0]                  out_x_reg, out_x_next;
    logic [CB-1:0]                  out_y_reg, out_y_next;
    logic [AB-1:0]                  out_alpha_reg, out_alpha_next;
    logic                           last_reg, last_next;

    logic                           div_start;
    logic [MB-1:0]                  div_dividend;
    logic [CB-1:0]                  div_divisor;
    logic                           div_done;
    logic [MB-1:0]                  div_quotient;

    alr_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        logic [CB-1:0] adx;
        logic [CB-1:0] ady;
        logic          steep;
        logic [CB-1:0] maj0;
        logic [CB-1:0] min0;
        logic [CB-1:0] maj1;
        logic [CB-1:0] min1;
        logic [CB-1:0] dmin;
        logic [CB-1:0] floor_v;
        logic [CB-1:0] floor_p1;
        logic [FB-1:0] frac;
        logic [PB-1:0] prod;
        logic [AB-1:0] a0;
        logic [AB-1:0] a1;
        logic          push;
        logic [CB-1:0] push_x;
        logic [CB-1:0] push_y;
        logic [AB-1:0] push_alpha;
        logic          flush;

        state_next = state_reg;
        steep_next = steep_reg;
        neg_next = neg_reg;
        maj_next = maj_reg;
        maj_end_next = maj_end_reg;
        minor_next = minor_reg;
        grad_next = grad_reg;
        color_next = color_reg;
        alpha_next = alpha_reg;
        a1_next = a1_reg;
        pend_valid_next = pend_valid_reg;
        pend_x_next = pend_x_reg;
        pend_y_next = pend_y_reg;
        pend_alpha_next = pend_alpha_reg;
        strobe_next = 1'b0;
        out_x_next = out_x_reg;
        out_y_next = out_y_reg;
        out_alpha_next = out_alpha_reg;
        last_next = last_reg;
        div_start = 1'b0;
        push = 1'b0;
        push_x = '0;
        push_y = '0;
        push_alpha = '0;
        flush = 1'b0;

        adx = (end_x > start_x) ? end_x - start_x : start_x - end_x;
        ady = (end_y > start_y) ? end_y - start_y : start_y - end_y;
        steep = (ady > adx);
        maj0 = steep ? start_y : start_x;
        min0 = steep ? start_x : start_y;
        maj1 = steep ? end_y : end_x;
        min1 = steep ? end_x : end_y;
        if (maj0 > maj1)
        begin
            {maj0, maj1} = {maj1, maj0};
            {min0, min1} = {min1, min0};
        end
        dmin = (min1 >= min0) ? min1 - min0 : min0 - min1;
        div_dividend = {dmin, {FB{1'b0}}};
        div_divisor = maj1 - maj0;

        floor_v = minor_reg[MB-1:FB];
        floor_p1 = floor_v + 1'b1;
        frac = minor_reg[FB-1:0];
        prod = PB'(alpha_reg) * PB'(frac);
        a1 = prod[PB-1:FB];
        a0 = alpha_reg - a1 - AB'(|prod[FB-1:0]);

        case (state_reg)
            alr_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    steep_next = steep;
                    neg_next = (min1 < min0);
                    maj_next = maj0;
                    maj_end_next = maj1;
                    minor_next = {min0, {FB{1'b0}}};
                    color_next = line_color[alr_pkg::COLOR_BITS-1:AB];
                    alpha_next = line_color[AB-1:0];
                    if (maj1 == maj0)
                    begin
                        grad_next = alr_pkg::FRAC_ONE;
                        state_next = alr_pkg::ST_PIX0;
                    end
                    else
                    begin
                        div_start = 1'b1;
                        state_next = alr_pkg::ST_DIV;
                    end
                end
            end
            alr_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    grad_next = neg_reg ? MB'(0) - div_quotient : div_quotient;
                    state_next = alr_pkg::ST_PIX0;
                end
            end
            alr_pkg::ST_PIX0:
            begin
                a1_next = a1;
                if (a0 != '0)
                begin
                    push = 1'b1;
                    push_x = steep_reg ? floor_v : maj_reg;
                    push_y = steep_reg ? maj_reg : floor_v;
                    push_alpha = a0;
                end
                state_next = alr_pkg::ST_PIX1;
            end
            alr_pkg::ST_PIX1:
            begin
                if (a1_reg != '0)
                begin
                    push = 1'b1;
                    push_x = steep_reg ? floor_p1 : maj_reg;
                    push_y = steep_reg ? maj_reg : floor_p1;
                    push_alpha = a1_reg;
                end
                if (maj_reg == maj_end_reg)
                begin
                    state_next = alr_pkg::ST_FLUSH;
                end
                else
                begin
                    maj_next = maj_reg + 1'b1;
                    minor_next = minor_reg + grad_reg;
                    state_next = alr_pkg::ST_PIX0;
                end
            end
            alr_pkg::ST_FLUSH:
            begin
                flush = 1'b1;
                state_next = alr_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = alr_pkg::ST_IDLE;
            end
        endcase

        if ((push || flush) && pend_valid_reg)
        begin
            strobe_next = 1'b1;
            out_x_next = pend_x_reg;
            out_y_next = pend_y_reg;
            out_alpha_next = pend_alpha_reg;
            last_next = flush;
        end
        if (push)
        begin
            pend_valid_next = 1'b1;
            pend_x_next = push_x;
            pend_y_next = push_y;
            pend_alpha_next = push_alpha;
        end
        else if (flush)
        begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= alr_pkg::ST_IDLE;
            pend_valid_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        steep_reg <= steep_next;
        neg_reg <= neg_next;
        maj_reg <= maj_next;
        maj_end_reg <= maj_end_next;
        minor_reg <= minor_next;
        grad_reg <= grad_next;
        color_reg <= color_next;
        alpha_reg <= alpha_next;
        a1_reg <= a1_next;
        pend_x_reg <= pend_x_next;
        pend_y_reg <= pend_y_next;
        pend_alpha_reg <= pend_alpha_next;
        out_x_reg <= out_x_next;
        out_y_reg <= out_y_next;
        out_alpha_reg <= out_alpha_next;
        last_reg <= last_next;
    end

    assign busy = (state_reg != alr_pkg::ST_IDLE);
    assign strobe = strobe_reg;
    assign pixel_x = out_x_reg;
    assign pixel_y = out_y_reg;
    assign pixel_color = {color_reg, out_alpha_reg};
    assign last_pixel = last_reg;

    `ALR_ASSERT(a_no_pixel_after_accept, start && !busy |=> !strobe,
        "pixel strobe in the cycle after a request was taken")
    `ALR_ASSERT(a_quiet_after_last, strobe && last_pixel |=> !strobe,
        "pixel strobe right after the last pixel of a line")
    `ALR_ASSERT_ALWAYS(a_no_zero_alpha, !strobe || (pixel_color[AB-1:0] != '0),
        "pixel with zero alpha was sent")
    `ALR_ASSERT_ALWAYS(a_idle_empty, busy || !pend_valid_reg,
        "held pixel left behind while idle")

endmodule

`default_nettype wire

// ===== src/alr_divider.sv =====
// Iterative restoring divider for the line gradient, one quotient bit per cycle.
// Depends on alr_pkg for the coordinate and fraction widths.
`default_nettype none

module alr_divider (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [alr_pkg::MINOR_BITS-1:0]    dividend,
    input  wire logic [alr_pkg::COORD_BITS-1:0]    divisor,
    output logic                                   done,
    output logic [alr_pkg::MINOR_BITS-1:0]         quotient
);

    logic                                active_reg;
    logic                                done_reg;
    logic [alr_pkg::DIV_CNT_BITS-1:0]    count_reg;
    logic [alr_pkg::MINOR_BITS-1:0]      quot_reg;
    logic [alr_pkg::MINOR_BITS-1:0]      quot_next;
    logic [alr_pkg::COORD_BITS-1:0]      rem_reg;
    logic [alr_pkg::COORD_BITS-1:0]      rem_next;
    logic [alr_pkg::COORD_BITS-1:0]      divisor_reg;
    logic [alr_pkg::COORD_BITS:0]        shifted;
    logic [alr_pkg::COORD_BITS-1:0]      diff;
    logic                                ge;

    always_comb
    begin
        shifted = {rem_reg, quot_reg[alr_pkg::MINOR_BITS-1]};
        diff = shifted[alr_pkg::COORD_BITS-1:0] - divisor_reg;
        ge = (shifted >= {1'b0, divisor_reg});
        rem_next = ge ? diff : shifted[alr_pkg::COORD_BITS-1:0];
        quot_next = {quot_reg[alr_pkg::MINOR_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                count_reg <= '0;
            end
            else if (active_reg)
            begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == alr_pkg::DIV_CNT_BITS'(alr_pkg::MINOR_BITS - 1))
                begin
                    active_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg <= '0;
            divisor_reg <= divisor;
        end
        else if (active_reg)
        begin
            quot_reg <= quot_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire
